### hdl/hsfd_pkg.sv
`default_nettype none

package hsfd_pkg;

   // Frame kinds; the unused code decodes as a humidity frame.
   localparam logic [1:0] FUNC_USER = 2'd0;
   localparam logic [1:0] FUNC_TEMP = 2'd1;
   localparam logic [1:0] FUNC_HUM  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_ZERO    = 2'd2
   } status_type;

   // CRC-8, polynomial x^8+x^5+x^4+1 (0x131), init 0, MSB first, no final XOR.
   // Only the low eight bits of the polynomial enter the shift.
   localparam logic [7:0] CRC_POLY_LOW = 8'h31;
   localparam logic [7:0] CRC_INIT     = 8'h00;

   // Raw value with the two status bits masked off (raw & 0xFFFC) is 4*y, y 14 bits.
   localparam int RAW_Y_W = 14;

   // Temperature: floor(raw*512/9548) = floor(y*512/2387)
   //   = (y * ceil(2^35/2387)) >> 26, exact for every 14-bit y.
   localparam int              TEMP_MUL_W  = 24;
   localparam logic [23:0]     TEMP_MUL    = 24'd14394529;
   localparam int              TEMP_SHIFT  = 26;
   localparam int              TEMP_PROD_W = RAW_Y_W + TEMP_MUL_W;
   localparam logic signed [12:0] TEMP_OFFSET = 13'sd937;

   // Humidity: floor(raw*256/134215) = floor(y*1024/134215)
   //   = (y * ceil(2^42/134215)) >> 32, exact for every 14-bit y.
   localparam int              HUM_MUL_W   = 25;
   localparam logic [24:0]     HUM_MUL     = 25'd32768667;
   localparam int              HUM_SHIFT   = 32;
   localparam int              HUM_PROD_W  = RAW_Y_W + HUM_MUL_W;
   localparam logic [6:0]      HUM_OFFSET  = 7'd6;

   localparam int READING_W = 12;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
      logic [7:0] crc_first;   // running CRC after the first byte
   } frame_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY_LOW;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/humidity_sensor_frame_decode.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  func, first_byte, second_byte, third_byte
// rsp_      out        rsp_valid / rsp_stall  status, reading
//
// One frame per cycle sustained while rsp_ is not stalled; each frame passes from its transfer
// on req_ through the input register, then the result register, to rsp_.
// Between the two registers lies a single decode pass: the second CRC byte, one
// constant multiply per measurement kind and a small fix-up.
// Reset is synchronous and clears both valid flags; payload registers keep junk.
// A stall on rsp_ holds the result; req_stall rises only when both stages are full.

module humidity_sensor_frame_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_func,
   input  wire logic [7:0]         req_first_byte,
   input  wire logic [7:0]         req_second_byte,
   input  wire logic [7:0]         req_third_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [11:0]      rsp_reading
);
   import hsfd_pkg::*;

   logic               frame_valid;
   frame_type          frame;
   status_type         dec_status;
   logic signed [11:0] dec_reading;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         status_ff;
   status_type         status_in;
   logic signed [11:0] reading_ff;
   logic signed [11:0] reading_in;
   logic               out_advance;

   // Input register; also folds the first byte into the CRC on the way in.
   hsfd_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_first_byte  (req_first_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .out_advance     (out_advance),
      .frame_valid     (frame_valid),
      .frame           (frame)
   );

   // Check CRC and convert the reading in one pass.
   hsfd_decode u_decode (
      .frame   (frame),
      .status  (dec_status),
      .reading (dec_reading)
   );

   // Result register advances when empty or when its transfer completes.
   assign out_advance  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_advance ? frame_valid : rsp_valid_ff;

   always_comb begin
      status_in  = status_ff;
      reading_in = reading_ff;
      if (out_advance && frame_valid) begin
         status_in  = dec_status;
         reading_in = dec_reading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      reading_ff <= reading_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_reading = reading_ff;

   // Stall the input only when both stages are full and the output is held.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (frame_valid && rsp_valid_ff && rsp_stall))
      else $error("req_stall raised with room in the pipeline");

   // An accepted transfer lands in the input stage.
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> frame_valid)
      else $error("accepted frame lost at input stage");

   // A frame in the input stage moves into the result register when it advances.
   a_stage_to_result: assert property (@(posedge clock) disable iff (reset)
      (frame_valid && out_advance) |=> rsp_valid_ff)
      else $error("frame lost between stages");

   // Error results carry a zero reading.
   a_error_zero_reading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != STATUS_OK)) |-> (reading_ff == 12'sd0))
      else $error("error status with nonzero reading");

endmodule

`default_nettype wire

### hdl/hsfd_in_stage.sv
`default_nettype none

module hsfd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_func,
   input  wire logic [7:0]        req_first_byte,
   input  wire logic [7:0]        req_second_byte,
   input  wire logic [7:0]        req_third_byte,
   input  wire logic              out_advance,
   output logic                   frame_valid,
   output hsfd_pkg::frame_type    frame
);
   import hsfd_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   logic      load;
   frame_type frame_ff;
   frame_type frame_in;

   // Stage frees up when empty or when its frame moves on this cycle.
   assign load      = !valid_ff || out_advance;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_comb begin
      frame_in             = frame_ff;
      if (load && req_valid) begin
         frame_in.func        = req_func;
         frame_in.first_byte  = req_first_byte;
         frame_in.second_byte = req_second_byte;
         frame_in.third_byte  = req_third_byte;
         frame_in.crc_first   = crc8_byte(CRC_INIT, req_first_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame_valid = valid_ff;
   assign frame       = frame_ff;

endmodule

`default_nettype wire

### hdl/hsfd_decode.sv
`default_nettype none

module hsfd_decode (
   input  wire hsfd_pkg::frame_type   frame,
   output hsfd_pkg::status_type       status,
   output logic signed [11:0]         reading
);
   import hsfd_pkg::*;

   logic [7:0]              crc_meas;
   logic [RAW_Y_W-1:0]      raw_y;
   logic [TEMP_PROD_W-1:0]  temp_prod;
   logic [11:0]             temp_q;
   logic signed [12:0]      temp_diff;
   logic signed [12:0]      temp_half;
   logic [HUM_PROD_W-1:0]   hum_prod;
   logic [6:0]              hum_q;
   logic [6:0]              hum_pct;

   assign crc_meas = crc8_byte(frame.crc_first, frame.second_byte);
   assign raw_y    = {frame.first_byte, frame.second_byte[7:2]};

   // Temperature in tenths; halve with truncation toward zero.
   assign temp_prod = TEMP_PROD_W'(raw_y) * TEMP_PROD_W'(TEMP_MUL);
   assign temp_q    = temp_prod[TEMP_SHIFT +: 12];
   assign temp_diff = $signed({1'b0, temp_q}) - TEMP_OFFSET;
   assign temp_half = (temp_diff + $signed({12'd0, temp_diff[12]})) >>> 1;

   // Humidity in percent, clamped at zero.
   assign hum_prod = HUM_PROD_W'(raw_y) * HUM_PROD_W'(HUM_MUL);
   assign hum_q    = hum_prod[HUM_SHIFT +: 7];
   assign hum_pct  = (hum_q < HUM_OFFSET) ? 7'd0 : (hum_q - HUM_OFFSET);

   always_comb begin
      status  = STATUS_OK;
      reading = '0;
      if (frame.func == FUNC_USER) begin
         priority if (frame.first_byte == 8'd0) begin
            status = STATUS_ZERO;
         end else if (frame.second_byte == frame.crc_first) begin
            reading = $signed({4'd0, frame.first_byte});
         end else begin
            status = STATUS_CRC_ERR;
         end
      end else if (frame.third_byte != crc_meas) begin
         status = STATUS_CRC_ERR;
      end else if (frame.func == FUNC_TEMP) begin
         reading = temp_half[11:0];
      end else begin
         reading = $signed({5'd0, hum_pct});
      end
   end

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;

   import hsfd_pkg::*;

   // The package names three frame kinds; the fourth code decodes as humidity.
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   // Polynomial x^8+x^5+x^4+1 with the x^8 term dropped, as the shift sees it.
   localparam logic [7:0] CRC8_TAPS = 8'h31;

   localparam int RANDOM_FRAMES   = 1200;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int PRESSURE_AFTER  = 300;
   localparam int PRESSURE_CYCLES = 80;

   // How a stimulus row gets its CRC byte: as typed, computed, or computed and corrupted.
   typedef enum logic [1:0] {
      CRC_AS_TYPED,
      CRC_GOOD,
      CRC_BAD
   } crc_fill_type;

   // Where the expectation of a row comes from.
   typedef enum logic {
      EXPECT_PREDICTED,
      EXPECT_TYPED
   } expect_src_type;

   typedef struct packed {
      status_type         status;
      logic signed [11:0] reading;
   } decode_result_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         first_byte;
      logic [7:0]         second_byte;
      logic [7:0]         third_byte;
      crc_fill_type       crc_fill;
      expect_src_type     expect_src;
      status_type         status;
      logic signed [11:0] reading;
   } frame_row_type;

   localparam int DIRECTED_COUNT = 23;

   // Directed frames: zero and bad-CRC user registers, the temperature and humidity
   // extremes, masking of the two status bits, the humidity clamp, the spare kind.
   frame_row_type directed_frames [DIRECTED_COUNT] = '{
      '{FUNC_USER,  8'h00, 8'h00, 8'h00, CRC_AS_TYPED, EXPECT_TYPED, STATUS_ZERO,    12'sd0},
      '{FUNC_USER,  8'h00, 8'hFF, 8'hFF, CRC_AS_TYPED, EXPECT_TYPED, STATUS_ZERO,    12'sd0},
      '{FUNC_USER,  8'h01, 8'h00, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_USER,  8'hFF, 8'h00, 8'hFF, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_USER,  8'h80, 8'h00, 8'h5A, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_USER,  8'h80, 8'h00, 8'h00, CRC_BAD,  EXPECT_TYPED,     STATUS_CRC_ERR, 12'sd0},
      '{FUNC_TEMP,  8'h00, 8'h00, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,    -12'sd468},
      '{FUNC_TEMP,  8'hFF, 8'hFF, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,     12'sd1288},
      '{FUNC_TEMP,  8'hFF, 8'hFF, 8'h00, CRC_BAD,  EXPECT_TYPED,     STATUS_CRC_ERR, 12'sd0},
      '{FUNC_TEMP,  8'h00, 8'h03, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,    -12'sd468},
      '{FUNC_TEMP,  8'h44, 8'h41, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_TEMP,  8'h44, 8'h44, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_TEMP,  8'h43, 8'hF8, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_HUM,   8'h00, 8'h00, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,      12'sd0},
      '{FUNC_HUM,   8'hFF, 8'hFF, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,      12'sd118},
      '{FUNC_HUM,   8'hFF, 8'hFC, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,      12'sd118},
      '{FUNC_HUM,   8'h0C, 8'h4C, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_HUM,   8'h0C, 8'h00, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0},
      '{FUNC_HUM,   8'h80, 8'h00, 8'h00, CRC_BAD,  EXPECT_TYPED,     STATUS_CRC_ERR, 12'sd0},
      '{FUNC_SPARE, 8'hFF, 8'hFF, 8'h00, CRC_GOOD, EXPECT_TYPED,     STATUS_OK,      12'sd118},
      '{FUNC_SPARE, 8'h12, 8'h34, 8'h00, CRC_BAD,  EXPECT_TYPED,     STATUS_CRC_ERR, 12'sd0},
      '{FUNC_TEMP,  8'hAA, 8'h55, 8'hC3, CRC_AS_TYPED, EXPECT_PREDICTED, STATUS_OK,  12'sd0},
      '{FUNC_HUM,   8'h55, 8'hAA, 8'h00, CRC_GOOD, EXPECT_PREDICTED, STATUS_OK,      12'sd0}
   };

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func        = FUNC_USER;
   logic [7:0]         req_first_byte  = 8'h00;
   logic [7:0]         req_second_byte = 8'h00;
   logic [7:0]         req_third_byte  = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [11:0] rsp_reading;

   // Results still owed by the block, oldest first.
   decode_result_type pending_results [$];

   int error_count   = 0;
   int results_seen  = 0;
   int idle_cycles   = 0;
   int burst_left    = 0;
   bit pressure_done = 1'b0;

   humidity_sensor_frame_decode dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_first_byte  (req_first_byte),
      .req_second_byte (req_second_byte),
      .req_third_byte  (req_third_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_reading     (rsp_reading)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // One byte through the CRC-8 shift register, MSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] remainder,
                                              input logic [7:0] data);
      logic [7:0] shift_reg;
      shift_reg = remainder ^ data;
      for (int bit_idx = 0; bit_idx < 8; bit_idx++) begin
         shift_reg = shift_reg[7] ? ({shift_reg[6:0], 1'b0} ^ CRC8_TAPS)
                                  : {shift_reg[6:0], 1'b0};
      end
      return shift_reg;
   endfunction

   // CRC that a well-formed frame carries: over one byte for the user register,
   // over both measurement bytes otherwise.
   function automatic logic [7:0] frame_crc(input logic [1:0] func,
                                            input logic [7:0] first_byte,
                                            input logic [7:0] second_byte);
      logic [7:0] crc_first;
      crc_first = crc8_update(8'h00, first_byte);
      return (func == FUNC_USER) ? crc_first : crc8_update(crc_first, second_byte);
   endfunction

   // Decode one frame into status and reading.
   function automatic decode_result_type decode_frame(input logic [1:0] func,
                                                      input logic [7:0] first_byte,
                                                      input logic [7:0] second_byte,
                                                      input logic [7:0] third_byte);
      decode_result_type result;
      int raw;
      int quotient;
      int value;
      result.status  = STATUS_OK;
      result.reading = '0;
      if (func == FUNC_USER) begin
         // A zero register wins over the CRC check.
         if (first_byte == 8'h00) begin
            result.status = STATUS_ZERO;
         end else if (second_byte == frame_crc(func, first_byte, second_byte)) begin
            result.reading = 12'(first_byte);
         end else begin
            result.status = STATUS_CRC_ERR;
         end
      end else if (third_byte != frame_crc(func, first_byte, second_byte)) begin
         result.status = STATUS_CRC_ERR;
      end else begin
         // Drop the two status bits of the raw value.
         raw = int'({first_byte, second_byte} & 16'hFFFC);
         if (func == FUNC_TEMP) begin
            quotient = (raw * 512) / 9548;
            // Signed int division truncates toward zero, as required.
            value = (quotient - 937) / 2;
         end else begin
            // Temperature aside, every other code is humidity; clamp below at zero.
            value = (raw * 256) / 134215 - 6;
            if (value < 0) begin
               value = 0;
            end
         end
         result.reading = 12'(value);
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Offer one frame and hold it until the block takes it; book the expectation
   // at the transfer edge.
   task automatic drive_frame(input logic [1:0] func,
                              input logic [7:0] first_byte,
                              input logic [7:0] second_byte,
                              input logic [7:0] third_byte,
                              input decode_result_type expected);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_first_byte  <= first_byte;
      req_second_byte <= second_byte;
      req_third_byte  <= third_byte;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_results.push_back(expected);
   endtask

   // Sender pacing: bursts of random length, random gaps between them. A gap of
   // zero merges two bursts, which gives stretches with no idling at all.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // Stimulus: reset, the directed table, then random frames, then drain.
   initial begin
      frame_row_type     row;
      decode_result_type expected;
      logic [1:0]        func;
      logic [7:0]        first_byte;
      logic [7:0]        second_byte;
      logic [7:0]        third_byte;
      logic [7:0]        good_crc;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; fill in CRC bytes where the row asks for them.
      for (int row_idx = 0; row_idx < DIRECTED_COUNT; row_idx++) begin
         row         = directed_frames[row_idx];
         second_byte = row.second_byte;
         third_byte  = row.third_byte;
         good_crc    = frame_crc(row.func, row.first_byte, row.second_byte);
         if (row.crc_fill != CRC_AS_TYPED) begin
            if (row.func == FUNC_USER) begin
               second_byte = (row.crc_fill == CRC_GOOD) ? good_crc : good_crc ^ 8'h01;
            end else begin
               third_byte = (row.crc_fill == CRC_GOOD) ? good_crc : good_crc ^ 8'h01;
            end
         end
         if (row.expect_src == EXPECT_TYPED) begin
            expected.status  = row.status;
            expected.reading = row.reading;
         end else begin
            expected = decode_frame(row.func, row.first_byte, second_byte, third_byte);
         end
         drive_frame(row.func, row.first_byte, second_byte, third_byte, expected);
         pace_sender();
      end

      // Random frames: mostly well-formed with random content, the rest with a
      // corrupt or random CRC. Every kind code, including the spare one, appears.
      for (int frame_idx = 0; frame_idx < RANDOM_FRAMES; frame_idx++) begin
         func        = 2'($urandom_range(0, 3));
         first_byte  = 8'($urandom_range(0, 255));
         second_byte = 8'($urandom_range(0, 255));
         third_byte  = 8'($urandom_range(0, 255));
         if (func == FUNC_USER && $urandom_range(0, 15) == 0) begin
            first_byte = 8'h00;
         end
         if ($urandom_range(0, 3) != 0) begin
            good_crc = frame_crc(func, first_byte, second_byte);
            if (func == FUNC_USER) begin
               second_byte = good_crc;
            end else begin
               third_byte = good_crc;
            end
         end
         expected = decode_frame(func, first_byte, second_byte, third_byte);
         drive_frame(func, first_byte, second_byte, third_byte, expected);
         pace_sender();
      end
      req_valid <= 1'b0;

      // Drain: wait for every booked result, then a few cycles for strays.
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         report_mismatch("results never delivered", 0, pending_results.size());
      end
      if (error_count == 0) begin
         $display("humidity_sensor_frame_decode verification clean");
      end else begin
         $display("humidity_sensor_frame_decode verification failed");
      end
      $finish;
   end

   // Receiver stall pattern: runs of free flow, random stalls, heavy stalls and
   // toggling. Once, after a few hundred results, hold off long enough for both
   // stages to fill and push back on the sender.
   initial begin
      int mode;
      int run_len;
      forever begin
         if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(4, 40);
         repeat (run_len) begin
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 7) != 0);
               end
               default: begin
                  rsp_stall <= ~rsp_stall;
               end
            endcase
            @(posedge clock);
         end
      end
   end

   // Result checker: compare each transfer against the oldest expectation.
   always @(posedge clock) begin
      decode_result_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", int'(rsp_status), -1);
         end else begin
            expected = pending_results.pop_front();
            if (rsp_status !== expected.status) begin
               report_mismatch("status", int'(rsp_status), int'(expected.status));
            end
            if (rsp_reading !== expected.reading) begin
               report_mismatch("reading", int'(rsp_reading), int'(expected.reading));
            end
         end
         results_seen <= results_seen + 1;
      end
   end

   // Watchdog: advance on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("humidity_sensor_frame_decode verification failed");
         $finish;
      end
   end

endmodule

`default_nettype wire
